FILE: rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types and constants of the character display text buffer
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int DEFAULT_ROWS = 2;
  localparam int DEFAULT_COLS = 16;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_EOL    = 3'd2,
    OP_UP     = 3'd3,
    OP_RIGHT  = 3'd4,
    OP_DOWN   = 3'd5,
    OP_LEFT   = 3'd6,
    OP_SETPOS = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UP_BOUND  = 3'd1,
    ST_RT_BOUND  = 3'd2,
    ST_DN_BOUND  = 3'd3,
    ST_LT_BOUND  = 3'd4,
    ST_OUT_BOUND = 3'd5,
    ST_BAD_CHAR  = 3'd6,
    ST_EOL_PAST  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PAD,
    S_STORE,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       read_cell;
    logic [7:0] char_code;
    logic [7:0] target_row;
    logic [7:0] target_col;
    logic [4:0] cell_index;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic       cursor_row;
    logic [3:0] cursor_col;
    logic [5:0] fill_length;
    logic [7:0] cell_char;
    logic       cell_filled;
  } result_t;

endpackage

FILE: rtl/char_lcd_text_buffer_cursor_core.sv
// ----------------------------------------------------------------------------
// char_lcd_text_buffer_cursor_core
// character display text store with cursor, one command per request
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  in_     | in  | in_tvalid / in_tready | tuser op, read_cell; tdata char,
//          |     |                       | target row/col, cell index
//  out_    | out | out_tvalid/out_tready | tuser status, filled; tdata cursor,
//          |     |                       | fill length, cell char
//
//  a plain command steps from accept to the next accept through decode,
//  cell read issue, read data return into the output register, then ready
//  a character write adds a pad check step and a store step, plus a pad
//  write per padded cell (cursor address minus fill length), one at a time
//  through the single cell store port
//  reset clears cursor and fill length; the cell store needs no clearing pass
//  a stalled result holds in the output register while the next request is
//  taken; that request waits only in its final step for the register to free
//
module char_lcd_text_buffer_cursor_core
  import clcd_pkg::*;
#(
  parameter int ROWS = DEFAULT_ROWS,
  parameter int COLS = DEFAULT_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code, target_row, target_col, cell_index, zero pad
  input  logic [3:0]  in_tuser,   // op, read_cell
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cursor_row, cursor_col, fill_length, cell_char, zero pad
  output logic [3:0]  out_tuser   // status, cell_filled
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  cmd_t          cmd;
  result_t       res;
  logic          res_valid;
  logic          res_ready;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  // unpack the request
  always_comb begin
    cmd.op         = op_t'(in_tuser[2:0]);
    cmd.read_cell  = in_tuser[3];
    cmd.char_code  = in_tdata[7:0];
    cmd.target_row = in_tdata[15:8];
    cmd.target_col = in_tdata[23:16];
    cmd.cell_index = in_tdata[28:24];
  end

  clcd_ctrl #(
    .ROWS  (ROWS),
    .COLS  (COLS),
    .CELLS (CELLS),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  clcd_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // output register, free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.cell_filled, out_res_r.status};
  assign out_tdata  = {5'd0, out_res_r.cell_char, out_res_r.fill_length,
                       out_res_r.cursor_col, out_res_r.cursor_row};

  // fill length never exceeds the grid
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[10:5]) <= 32'(CELLS)))
    else $error("fill length beyond grid");

  // a filled cell implies a nonzero fill length
  a_filled_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tdata[10:5] != 6'd0))
    else $error("filled cell with empty text");

  // reported cursor stays inside the grid
  a_cursor_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((32'(out_tdata[4:1]) < 32'(COLS)) && (32'(out_tdata[0]) < 32'(ROWS))))
    else $error("cursor outside grid");

  // a filled cell implies a nonzero fill length unless the grid exceeds 63 cells
  a_filled_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tdata[10:5] != 6'd0 || CELLS > 63))
    else $error("filled flag without text");

endmodule

FILE: rtl/clcd_cell_ram.sv
// ----------------------------------------------------------------------------
// clcd_cell_ram
// single port cell store, registered read data
// ----------------------------------------------------------------------------
module clcd_cell_ram
  import clcd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_ROWS * DEFAULT_COLS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/clcd_ctrl.sv
// ----------------------------------------------------------------------------
// clcd_ctrl
// command sequencer: cursor, fill length, padding sweep and cell access
// ----------------------------------------------------------------------------
module clcd_ctrl
  import clcd_pkg::*;
#(
  parameter int ROWS  = DEFAULT_ROWS,
  parameter int COLS  = DEFAULT_COLS,
  parameter int CELLS = ROWS * COLS,
  parameter int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cmd_t          in_cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res,
  output logic          ram_en,
  output logic          ram_we,
  output logic [AW-1:0] ram_addr,
  output logic [7:0]    ram_wdata,
  input  logic [7:0]    ram_rdata
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LW = $clog2(CELLS + 1);
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
  localparam logic [8:0] ROWS9  = 9'(ROWS);
  localparam logic [8:0] COLS9  = 9'(COLS);
  localparam logic [8:0] CELLS9 = 9'(CELLS);

  function automatic logic char_ok(input logic [7:0] c);
    logic ok;
    ok = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    unique case (c)
      " ", ".", ":", ",", ";", "'", "\"", "(", ")",
      "!", "?", "+", "*", "/", "=", "<", ">", "-", "_": ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [LW-1:0] len_r, len_nxt;
  status_t       status_r, status_nxt;
  logic          hit_r, hit_nxt;

  logic [LW-1:0] pos;
  logic [RW-1:0] mr_row;
  logic [CW-1:0] mr_col;
  logic          mr_bound;

  // linear cursor address
  assign pos = LW'(row_r) * LW'(COLS) + LW'(col_r);

  // right step with wrap onto the next row
  always_comb begin
    mr_row   = row_r;
    mr_col   = col_r;
    mr_bound = 1'b0;
    if (col_r == COL_LAST && row_r < ROW_LAST) begin
      mr_col = '0;
      mr_row = row_r + RW'(1);
    end else if (col_r < COL_LAST) begin
      mr_col = col_r + CW'(1);
    end else begin
      mr_bound = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = AW'(cmd_r.cell_index);
    ram_wdata  = cmd_r.char_code;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        state_nxt  = S_READ;
        if (!cmd_r.read_cell) begin
          unique case (cmd_r.op)
            OP_WRITE: begin
              if (!char_ok(cmd_r.char_code)) begin
                status_nxt = ST_BAD_CHAR;
              end else begin
                state_nxt = S_PAD;
              end
            end
            OP_CLEAR: begin
              len_nxt = '0;
              row_nxt = '0;
              col_nxt = '0;
            end
            OP_EOL: begin
              if (pos > len_r) begin
                status_nxt = ST_EOL_PAST;
              end else begin
                len_nxt = pos;
              end
            end
            OP_UP: begin
              if (row_r != '0) begin
                row_nxt = row_r - RW'(1);
              end else begin
                status_nxt = ST_UP_BOUND;
              end
            end
            OP_RIGHT: begin
              row_nxt = mr_row;
              col_nxt = mr_col;
              if (mr_bound) status_nxt = ST_RT_BOUND;
            end
            OP_DOWN: begin
              if (row_r < ROW_LAST) begin
                row_nxt = row_r + RW'(1);
              end else begin
                status_nxt = ST_DN_BOUND;
              end
            end
            OP_LEFT: begin
              if (col_r == '0 && row_r != '0) begin
                col_nxt = COL_LAST;
                row_nxt = row_r - RW'(1);
              end else if (col_r != '0) begin
                col_nxt = col_r - CW'(1);
              end else begin
                status_nxt = ST_LT_BOUND;
              end
            end
            OP_SETPOS: begin
              if ({1'b0, cmd_r.target_row} < ROWS9 && {1'b0, cmd_r.target_col} < COLS9) begin
                row_nxt = RW'(cmd_r.target_row);
                col_nxt = CW'(cmd_r.target_col);
              end else begin
                status_nxt = ST_OUT_BOUND;
              end
            end
          endcase
        end
      end
      S_PAD: begin
        // fill the gap below the cursor with spaces, one cell per cycle
        if (len_r < pos) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = AW'(len_r);
          ram_wdata = SPACE;
          len_nxt   = len_r + LW'(1);
        end else begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = AW'(pos);
        if (pos == len_r) len_nxt = len_r + LW'(1);
        row_nxt   = mr_row;
        col_nxt   = mr_col;
        if (mr_bound) status_nxt = ST_RT_BOUND;
        state_nxt = S_READ;
      end
      S_READ: begin
        hit_nxt = (9'(cmd_r.cell_index) < 9'(len_r)) && (9'(cmd_r.cell_index) < CELLS9);
        ram_en    = hit_nxt;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.cursor_row  = 1'(row_r);
    res.cursor_col  = 4'(col_r);
    res.fill_length = 6'(len_r);
    res.cell_char   = hit_r ? ram_rdata : SPACE;
    res.cell_filled = hit_r;
  end

endmodule
